FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/ckrt_pkg.sv
// ----------------------------------------------------------------------------
// ckrt_pkg
// Types and constants of the compacting keyed record table.
// ----------------------------------------------------------------------------
`default_nettype none

package ckrt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int CNT_W        = 7;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 12;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_LOOKUP = 3'd1,
        OP_UPDATE = 3'd2,
        OP_DELETE = 3'd3,
        OP_DUMP   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_DUP     = 3'd2,
        ST_MISSING = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACT,
        S_DUMP
    } t_state;

    typedef struct packed {
        logic [2:0]              operation;
        logic signed [KEY_W-1:0] record_key;
        logic [VAL_W-1:0]        record_value;
    } t_in;

    typedef struct packed {
        logic [2:0]              status;
        logic signed [KEY_W-1:0] out_key;
        logic [VAL_W-1:0]        out_value;
        logic [CNT_W-1:0]        entry_count;
        logic                    last;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } t_rec;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic             cmp;
        logic             ins;
        logic             upd;
        logic             del;
        logic             rot;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] del_idx;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: rtl/ckrt_cell.sv
// ----------------------------------------------------------------------------
// ckrt_cell
// One table slot: holds a record, compares it with a searched key and takes
// its neighbor's record when the table is compacted or rotated.
// ----------------------------------------------------------------------------
`default_nettype none

module ckrt_cell #(
    parameter int IDX = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ckrt_pkg::t_cell_ctl i_ctl,
    input  wire ckrt_pkg::t_rec      i_next,
    input  wire ckrt_pkg::t_rec      i_head,
    output ckrt_pkg::t_rec           o_rec,
    output logic                     o_hit
);

    localparam logic [ckrt_pkg::CNT_W-1:0] IDX_C   = ckrt_pkg::CNT_W'(IDX);
    localparam logic [ckrt_pkg::CNT_W-1:0] IDX_NXT = ckrt_pkg::CNT_W'(IDX + 1);

    ckrt_pkg::t_rec r_rec;
    ckrt_pkg::t_rec n_rec;
    logic           r_hit;
    logic           n_hit;
    logic           w_valid;

    assign w_valid = (IDX_C < i_ctl.count);
    assign n_hit   = w_valid && (r_rec.key == i_ctl.key);

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.ins && (IDX_C == i_ctl.count)) begin
            n_rec.key = i_ctl.key;
            n_rec.val = i_ctl.val;
        end else if (i_ctl.upd && r_hit) begin
            n_rec.val = i_ctl.val;
        end else if (i_ctl.del && (IDX_C >= i_ctl.del_idx) && (IDX_NXT < i_ctl.count)) begin
            n_rec = i_next;
        end else if (i_ctl.rot) begin
            // The occupied part of the chain turns over by one place.
            if (IDX_NXT < i_ctl.count) begin
                n_rec = i_next;
            end else if (IDX_NXT == i_ctl.count) begin
                n_rec = i_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_hit <= n_hit;
        end
    end

    assign o_rec = r_rec;
    assign o_hit = r_hit;

endmodule

`default_nettype wire

FILE: rtl/compacting_keyed_record_table.sv
// A lookup, update, delete or insert is taken while idle and resolved in the next cycle, in S_ACT;
// its registered result appears in the cycle after that, when a new command can already be taken.
// A dump of N entries passes through S_ACT into S_DUMP and then gives one result per cycle,
// N results in all, as the chain of cells turns over by one place per cycle.
// The receiver cannot stall; every result is shown for one cycle under o_strobe.
// Reset empties the table at once; record cells hold no reset value.
// ----------------------------------------------------------------------------
// compacting_keyed_record_table
// Packed table of unique keys with values, kept in insertion order in a
// chain of cells; deletion compacts the chain and dumps rotate it.
// ----------------------------------------------------------------------------
`default_nettype none

module compacting_keyed_record_table #(
    parameter int CAPACITY = ckrt_pkg::CAPACITY_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire ckrt_pkg::t_in  i_item,
    output logic                o_strobe,
    output ckrt_pkg::t_out      o_result
);

    localparam logic [ckrt_pkg::CNT_W-1:0] CAP_C = ckrt_pkg::CNT_W'(CAPACITY);
    localparam logic [ckrt_pkg::CNT_W-1:0] ONE_C = ckrt_pkg::CNT_W'(1);

    ckrt_pkg::t_state              r_state, n_state;
    logic [ckrt_pkg::CNT_W-1:0]    r_count, n_count;
    logic [ckrt_pkg::CNT_W-1:0]    r_dcnt, n_dcnt;
    logic [2:0]                    r_op, n_op;
    logic [ckrt_pkg::KEY_W-1:0]    r_key, n_key;
    logic [ckrt_pkg::VAL_W-1:0]    r_val, n_val;
    logic                          r_strobe, n_strobe;
    ckrt_pkg::t_out                r_res, n_res;

    ckrt_pkg::t_cell_ctl           w_ctl;
    ckrt_pkg::t_rec                w_rec  [CAPACITY];
    ckrt_pkg::t_rec                w_next [CAPACITY];
    logic [CAPACITY-1:0]           w_hit;
    logic                          w_hit_any;
    logic [ckrt_pkg::VAL_W-1:0]    w_hit_val;
    logic [ckrt_pkg::CNT_W-1:0]    w_hit_idx;
    logic                          w_accept;

    assign w_accept = start && (r_state == ckrt_pkg::S_IDLE);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == CAPACITY - 1) begin : g_end
                assign w_next[g] = w_rec[g];
            end else begin : g_mid
                assign w_next[g] = w_rec[g+1];
            end
            ckrt_cell #(.IDX(g)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_ctl),
                .i_next (w_next[g]),
                .i_head (w_rec[0]),
                .o_rec  (w_rec[g]),
                .o_hit  (w_hit[g])
            );
        end
    endgenerate

    // Keys are unique among occupied cells, so at most one hit bit is set.
    always_comb begin
        w_hit_val = '0;
        w_hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_hit[i]) begin
                w_hit_val = w_hit_val | w_rec[i].val;
                w_hit_idx = w_hit_idx | ckrt_pkg::CNT_W'(i);
            end
        end
    end
    assign w_hit_any = |w_hit;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_dcnt   = r_dcnt;
        n_op     = r_op;
        n_key    = r_key;
        n_val    = r_val;
        n_strobe = 1'b0;
        n_res    = '0;

        w_ctl         = '0;
        w_ctl.count   = r_count;
        w_ctl.del_idx = w_hit_idx;
        w_ctl.key     = r_key;
        w_ctl.val     = r_val;

        case (r_state)
            ckrt_pkg::S_IDLE: begin
                w_ctl.key = i_item.record_key;
                if (w_accept) begin
                    w_ctl.cmp = 1'b1;
                    n_op      = i_item.operation;
                    n_key     = i_item.record_key;
                    n_val     = i_item.record_value;
                    n_state   = ckrt_pkg::S_ACT;
                end
            end
            ckrt_pkg::S_ACT: begin
                n_state        = ckrt_pkg::S_IDLE;
                n_strobe       = 1'b1;
                n_res.status   = ckrt_pkg::ST_OK;
                n_res.last     = 1'b1;
                if (r_op == ckrt_pkg::OP_INSERT) begin
                    if (r_count >= CAP_C) begin
                        n_res.status = ckrt_pkg::ST_FULL;
                    end else if (w_hit_any) begin
                        n_res.status = ckrt_pkg::ST_DUP;
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + ONE_C;
                    end
                end else if (r_op > ckrt_pkg::OP_DUMP) begin
                    n_res.status = ckrt_pkg::ST_OK;
                end else if (r_count == '0) begin
                    n_res.status = ckrt_pkg::ST_EMPTY;
                end else if (r_op == ckrt_pkg::OP_DUMP) begin
                    n_strobe = 1'b0;
                    n_dcnt   = '0;
                    n_state  = ckrt_pkg::S_DUMP;
                end else if (!w_hit_any) begin
                    n_res.status = ckrt_pkg::ST_MISSING;
                end else begin
                    n_res.out_key   = r_key;
                    n_res.out_value = w_hit_val;
                    if (r_op == ckrt_pkg::OP_UPDATE) begin
                        w_ctl.upd       = 1'b1;
                        n_res.out_value = r_val;
                    end else if (r_op == ckrt_pkg::OP_DELETE) begin
                        w_ctl.del = 1'b1;
                        n_count   = r_count - ONE_C;
                    end
                end
                n_res.entry_count = n_count;
            end
            ckrt_pkg::S_DUMP: begin
                // Cell 0 always holds the next entry to emit while the chain turns.
                w_ctl.rot         = 1'b1;
                n_strobe          = 1'b1;
                n_res.status      = ckrt_pkg::ST_OK;
                n_res.out_key     = w_rec[0].key;
                n_res.out_value   = w_rec[0].val;
                n_res.entry_count = r_count;
                n_res.last        = (r_dcnt == r_count - ONE_C);
                n_dcnt            = r_dcnt + ONE_C;
                if (n_res.last) begin
                    n_state = ckrt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ckrt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ckrt_pkg::S_IDLE;
            r_count  <= '0;
            r_dcnt   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_dcnt   <= n_dcnt;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_key <= n_key;
        r_val <= n_val;
        r_res <= n_res;
    end

    assign busy     = (r_state != ckrt_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

`default_nettype wire

FILE: rtl/ckrt_checker.sv
// ----------------------------------------------------------------------------
// ckrt_checker
// Port-level checks on command acceptance and result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ckrt_checker #(
    parameter int CAPACITY = ckrt_pkg::CAPACITY_DEF
) (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire ckrt_pkg::t_in  i_item,
    input wire logic           o_strobe,
    input wire ckrt_pkg::t_out o_result
);

    localparam logic [ckrt_pkg::CNT_W-1:0] CAP_C = ckrt_pkg::CNT_W'(CAPACITY);

    logic w_accept;
    logic w_item_op_dump;

    assign w_accept       = start && !busy;
    assign w_item_op_dump = (i_item.operation == ckrt_pkg::OP_DUMP);

    // A transaction keeps the block occupied while it is resolved.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, busy)
    // No result is shown in the cycle that resolves a new transaction other than a dump.
    `ASSERT_NEXT(a_no_strobe_after_accept, i_clk, i_rst_n, w_accept && !w_item_op_dump, !o_strobe)
    // A dump result that is not the final one leaves the block still working.
    `ASSERT_SAME(a_more_results_busy, i_clk, i_rst_n, o_strobe && !o_result.last, busy)
    // The reported fill never exceeds the table size.
    `ASSERT_SAME(a_count_in_range, i_clk, i_rst_n, o_strobe, o_result.entry_count <= CAP_C)

endmodule

bind compacting_keyed_record_table ckrt_checker #(.CAPACITY(CAPACITY)) u_ckrt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_item  (i_item),
    .o_strobe(o_strobe),
    .o_result(o_result)
);

`default_nettype wire
